// File: hw/rtl/imhq_pkg.sv
// ---------------------------------------------------------------------------
// imhq_pkg - shared types and constants for the indexed min-heap queue
// Request/result payloads, function and status codes, sizing constants.
// ---------------------------------------------------------------------------
package imhq_pkg;

    localparam int CAPACITY = 256;
    localparam int ID_W     = 8;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_COUNT = 2 ** ID_W;

    typedef enum logic [1:0] {
        F_INSERT   = 2'd0,
        F_REMOVE   = 2'd1,
        F_DECREASE = 2'd2,
        F_PEEK     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_ABSENT = 3'd3,
        ST_DUP    = 3'd4
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [ID_W-1:0]    item_id;
        logic [KEY_W-1:0]   key_in;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    out_id;
        logic [KEY_W-1:0]   out_key;
        logic [CNT_W-1:0]   count;
        logic               is_empty;
    } t_rsp;

    // one heap slot
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [KEY_W-1:0]   key;
    } t_entry;

endpackage

// File: hw/rtl/indexed_min_heap_queue_top.sv
// ---------------------------------------------------------------------------
// indexed_min_heap_queue_top - indexed binary min-heap priority queue
// Insert, remove-min, decrease-key and peek on a 0-based heap held in a
// synchronous heap RAM plus an id-to-slot position RAM.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                 Direction  Transfer
//  -------   --------------------  ---------  ----------------------------
//  request   start, busy, i_req    in         rising edge, start & !busy
//  result    o_done, o_rsp         out        the one cycle o_done is high
//
//  Sequencing: one request at a time. Each heap level is a heap RAM read,
//  then compare and write back, up to 8 levels for 256 slots; decrease-key
//  adds the position RAM and old-key reads.
//  Reset: synchronous, active low; clears the count, the presence bits and
//  the sequencer. Heap and position RAMs are not cleared: only live slots
//  and positions of present ids are ever read.
//  Stalls: the receiver cannot stall; busy is low only in idle.
//
module indexed_min_heap_queue_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  imhq_pkg::t_req  i_req,
    output logic            o_done,
    output imhq_pkg::t_rsp  o_rsp
);

    localparam int AW = imhq_pkg::ADDR_W;
    localparam int CW = imhq_pkg::CNT_W;
    localparam int XW = imhq_pkg::ADDR_W + 2;   // child index and its sibling

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_POS    = 10'b00_0000_0010,  // position RAM data valid
        S_OLD    = 10'b00_0000_0100,  // old key of decreased entry valid
        S_TOP    = 10'b00_0000_1000,  // root and last slot valid
        S_UP_RD  = 10'b00_0001_0000,
        S_UP_CMP = 10'b00_0010_0000,
        S_DN_RD  = 10'b00_0100_0000,
        S_DN_CMP = 10'b00_1000_0000,
        S_FIN    = 10'b01_0000_0000,  // drop carried entry into the hole
        S_RESP   = 10'b10_0000_0000
    } t_state;

    // Heap memory: one write port, two registered read ports.
    imhq_pkg::t_entry       mem_heap [imhq_pkg::CAPACITY];
    // Position memory: slot of each id.
    logic [AW-1:0]          mem_pos  [imhq_pkg::ID_COUNT];

    logic [AW-1:0]          hp_ra_addr, hp_rb_addr, hp_waddr;
    logic                   hp_we;
    imhq_pkg::t_entry       hp_wdata;
    imhq_pkg::t_entry       r_hp_ra, r_hp_rb;

    logic [imhq_pkg::ID_W-1:0] pos_raddr, pos_waddr;
    logic                   pos_we;
    logic [AW-1:0]          pos_wdata;
    logic [AW-1:0]          r_pos_rd;

    // control state
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [imhq_pkg::ID_COUNT-1:0] r_present, n_present;

    // working registers
    imhq_pkg::t_func        r_func, n_func;
    logic [imhq_pkg::ID_W-1:0]  r_id, n_id;       // carried entry
    logic [imhq_pkg::KEY_W-1:0] r_key, n_key;
    logic [AW-1:0]          r_k, n_k;             // hole slot
    logic [AW-1:0]          r_c, n_c;             // parent or left child
    logic                   r_two, n_two;         // right child exists
    imhq_pkg::t_status      r_status, n_status;
    logic [imhq_pkg::ID_W-1:0]  r_oid, n_oid;
    logic [imhq_pkg::KEY_W-1:0] r_okey, n_okey;

    logic [XW-1:0]          child_l, child_r, cnt_x;
    imhq_pkg::t_entry       pick;
    logic [AW-1:0]          pick_idx;
    logic                   pick_right;

    assign child_l    = {1'b0, r_k, 1'b1};
    assign child_r    = child_l + XW'(1);
    assign cnt_x      = XW'(r_cnt);
    // left child wins ties
    assign pick_right = r_two && (r_hp_ra.key > r_hp_rb.key);
    assign pick       = pick_right ? r_hp_rb : r_hp_ra;
    assign pick_idx   = pick_right ? (r_c + AW'(1)) : r_c;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_present = r_present;
        n_func    = r_func;
        n_id      = r_id;
        n_key     = r_key;
        n_k       = r_k;
        n_c       = r_c;
        n_two     = r_two;
        n_status  = r_status;
        n_oid     = r_oid;
        n_okey    = r_okey;

        hp_ra_addr = '0;
        hp_rb_addr = '0;
        hp_we      = 1'b0;
        hp_waddr   = r_k;
        hp_wdata   = '{id: r_id, key: r_key};
        pos_raddr  = i_req.item_id;
        pos_we     = 1'b0;
        pos_waddr  = r_id;
        pos_wdata  = r_k;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func   = i_req.func;
                    n_id     = i_req.item_id;
                    n_key    = i_req.key_in;
                    n_status = imhq_pkg::ST_OK;
                    n_oid    = '0;
                    n_okey   = '0;
                    unique case (i_req.func)
                        imhq_pkg::F_INSERT: begin
                            if (r_cnt == CW'(imhq_pkg::CAPACITY)) begin
                                n_status = imhq_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else if (r_present[i_req.item_id]) begin
                                n_status = imhq_pkg::ST_DUP;
                                n_state  = S_RESP;
                            end else begin
                                n_k                       = r_cnt[AW-1:0];
                                n_cnt                     = r_cnt + CW'(1);
                                n_present[i_req.item_id]  = 1'b1;
                                n_state                   = S_UP_RD;
                            end
                        end
                        imhq_pkg::F_REMOVE, imhq_pkg::F_PEEK: begin
                            if (r_cnt == '0) begin
                                n_status = imhq_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                hp_ra_addr = '0;
                                hp_rb_addr = AW'(r_cnt - CW'(1));
                                n_state    = S_TOP;
                            end
                        end
                        imhq_pkg::F_DECREASE: begin
                            if (!r_present[i_req.item_id]) begin
                                n_status = imhq_pkg::ST_ABSENT;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_POS;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_POS: begin
                hp_ra_addr = r_pos_rd;
                n_k        = r_pos_rd;
                n_state    = S_OLD;
            end
            S_OLD: begin
                if (r_key < r_hp_ra.key) begin
                    n_state = S_UP_RD;
                end else if (r_key > r_hp_ra.key) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TOP: begin
                n_oid  = r_hp_ra.id;
                n_okey = r_hp_ra.key;
                if (r_func == imhq_pkg::F_PEEK) begin
                    n_state = S_RESP;
                end else begin
                    n_cnt                 = r_cnt - CW'(1);
                    n_present[r_hp_ra.id] = 1'b0;
                    // last entry becomes the carried one, hole at the root
                    n_id    = r_hp_rb.id;
                    n_key   = r_hp_rb.key;
                    n_k     = '0;
                    n_state = (r_cnt == CW'(1)) ? S_RESP : S_DN_RD;
                end
            end
            S_UP_RD: begin
                if (r_k == '0) begin
                    n_state = S_FIN;
                end else begin
                    hp_ra_addr = (r_k - AW'(1)) >> 1;
                    n_c        = (r_k - AW'(1)) >> 1;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_hp_ra.key > r_key) begin
                    hp_we     = 1'b1;
                    hp_wdata  = r_hp_ra;
                    pos_we    = 1'b1;
                    pos_waddr = r_hp_ra.id;
                    n_k       = r_c;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RD: begin
                if (child_l >= cnt_x) begin
                    n_state = S_FIN;
                end else begin
                    hp_ra_addr = child_l[AW-1:0];
                    hp_rb_addr = child_r[AW-1:0];
                    n_c        = child_l[AW-1:0];
                    n_two      = child_r < cnt_x;
                    n_state    = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (r_key > pick.key) begin
                    hp_we     = 1'b1;
                    hp_wdata  = pick;
                    pos_we    = 1'b1;
                    pos_waddr = pick.id;
                    n_k       = pick_idx;
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                hp_we   = 1'b1;
                pos_we  = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Every write lands before any read of the same
    // entry: slot moves go into the hole, reads go to parent or children,
    // and the final write is followed by the response cycle.
    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            mem_heap[hp_waddr] <= hp_wdata;
        end
        r_hp_ra <= mem_heap[hp_ra_addr];
        r_hp_rb <= mem_heap[hp_rb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            mem_pos[pos_waddr] <= pos_wdata;
        end
        r_pos_rd <= mem_pos[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_present <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_present <= n_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_id     <= n_id;
        r_key    <= n_key;
        r_k      <= n_k;
        r_c      <= n_c;
        r_two    <= n_two;
        r_status <= n_status;
        r_oid    <= n_oid;
        r_okey   <= n_okey;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = (r_state == S_RESP);
    assign o_rsp.status    = r_status;
    assign o_rsp.out_id    = r_oid;
    assign o_rsp.out_key   = r_okey;
    assign o_rsp.count     = r_cnt;
    assign o_rsp.is_empty  = (r_cnt == '0);

    // presence bits and entry count track each other
    a_cnt_matches_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'($countones(r_present)) == r_cnt)
        else $error("entry count differs from presence bits");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(imhq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not start a request");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("no return to idle after result");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == imhq_pkg::ST_EMPTY)) |-> (o_rsp.count == '0))
        else $error("empty status with entries held");

endmodule
